/* sv/qss_pkg.sv */
`timescale 1ns / 1ps
package qss_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int FRACTION_BITS = 16;
   localparam int COEF_WIDTH    = 48;
   localparam int MAX_SAMPLES   = 64;
   localparam int NUM_COEFS     = 6;

   localparam int IDX_WIDTH   = $clog2(MAX_SAMPLES);
   localparam int CNT_WIDTH   = IDX_WIDTH + 1;
   localparam int CSR_WIDTH   = 7;
   localparam int CSR_RESET   = 16;
   localparam int DUR_WIDTH   = DATA_WIDTH - 1;
   localparam int ACC_WIDTH   = COEF_WIDTH + 8;
   localparam int PROD_WIDTH  = ACC_WIDTH + CNT_WIDTH;
   localparam int DVD_WIDTH   = ACC_WIDTH + FRACTION_BITS;
   localparam int HALF_WIDTH  = COEF_WIDTH / 2;
   localparam int MPROD_WIDTH = COEF_WIDTH + DUR_WIDTH;
   localparam int KIDX_WIDTH  = 3;
   localparam int MSEL_WIDTH  = 3;

   // order of the boundary products: V0, V1, a0*T, (a0*T)*T, a1*T, (a1*T)*T
   localparam logic [MSEL_WIDTH-1:0] MSTEP_V0  = 3'd0;
   localparam logic [MSEL_WIDTH-1:0] MSTEP_V1  = 3'd1;
   localparam logic [MSEL_WIDTH-1:0] MSTEP_A0T = 3'd2;
   localparam logic [MSEL_WIDTH-1:0] MSTEP_B0  = 3'd3;
   localparam logic [MSEL_WIDTH-1:0] MSTEP_A1T = 3'd4;
   localparam logic [MSEL_WIDTH-1:0] MSTEP_B1  = 3'd5;

   localparam logic [1:0] FORM_POS = 2'd0;
   localparam logic [1:0] FORM_VEL = 2'd1;
   localparam logic [1:0] FORM_ACC = 2'd2;

   typedef struct packed {
      logic [1:0]                    axis_tag;
      logic signed [DATA_WIDTH-1:0]  start_position;
      logic signed [DATA_WIDTH-1:0]  end_position;
      logic signed [DATA_WIDTH-1:0]  start_velocity;
      logic signed [DATA_WIDTH-1:0]  end_velocity;
      logic signed [DATA_WIDTH-1:0]  start_acceleration;
      logic signed [DATA_WIDTH-1:0]  end_acceleration;
      logic [DUR_WIDTH-1:0]          duration;
   } req_type;

   typedef struct packed {
      logic [1:0]                    axis_out;
      logic [IDX_WIDTH-1:0]          sample_index;
      logic signed [DATA_WIDTH-1:0]  sample_position;
      logic signed [DATA_WIDTH-1:0]  sample_velocity;
      logic signed [DATA_WIDTH-1:0]  sample_acceleration;
      logic                          last_sample;
      logic                          singular_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_WR,
      ST_COEF,
      ST_H_INIT,
      ST_H_DIV,
      ST_H_WAIT,
      ST_H_ADD,
      ST_SAVE,
      ST_Q_START,
      ST_Q_WAIT,
      ST_Q_WR,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_MUL_WR,
      OP_COEF,
      OP_H_INIT,
      OP_H_DIV,
      OP_H_ADD,
      OP_Q_START,
      OP_Q_WR,
      OP_SET_POS,
      OP_SET_VEL,
      OP_EMIT,
      OP_EMIT_ERR
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [MSEL_WIDTH-1:0]  mul_sel;
      logic [KIDX_WIDTH-1:0]  coef_k;
      logic [1:0]             form;
      logic [IDX_WIDTH-1:0]   j;
      logic                   last;
   } cmd_type;

   typedef struct packed {
      logic                  dur_zero;
      logic                  div_done;
      logic                  out_free;
      logic [IDX_WIDTH-1:0]  last_index;
   } status_type;

   // Horner weight: 1, k or k(k-1) for position, velocity, acceleration
   function automatic logic [4:0] horner_weight(input logic [KIDX_WIDTH-1:0] k,
                                                input logic [1:0] form);
      logic [4:0] w;
      w = 5'd0;
      case (form)
         FORM_POS: w = 5'd1;
         FORM_VEL: w = {2'b00, k};
         FORM_ACC: begin
            case (k)
               3'd5:    w = 5'd20;
               3'd4:    w = 5'd12;
               3'd3:    w = 5'd6;
               3'd2:    w = 5'd2;
               default: w = 5'd0;
            endcase
         end
         default: w = 5'd0;
      endcase
      return w;
   endfunction

   // sample_count clamped to 2..MAX_SAMPLES, minus one
   function automatic logic [IDX_WIDTH-1:0] last_index(input logic [CSR_WIDTH-1:0] cfg);
      logic [CSR_WIDTH-1:0] n;
      if (cfg < CSR_WIDTH'(2)) begin
         n = CSR_WIDTH'(2);
      end else if (cfg > CSR_WIDTH'(MAX_SAMPLES)) begin
         n = CSR_WIDTH'(MAX_SAMPLES);
      end else begin
         n = cfg;
      end
      return IDX_WIDTH'(n - CSR_WIDTH'(1));
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_data(
         input logic signed [ACC_WIDTH-1:0] x);
      logic signed [ACC_WIDTH-1:0] hi;
      logic signed [ACC_WIDTH-1:0] lo;
      hi = $signed({{(ACC_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
      lo = ~hi;
      if (x > hi) begin
         return hi[DATA_WIDTH-1:0];
      end else if (x < lo) begin
         return lo[DATA_WIDTH-1:0];
      end
      return x[DATA_WIDTH-1:0];
   endfunction

   function automatic logic signed [COEF_WIDTH-1:0] sat_coef(
         input logic signed [ACC_WIDTH-1:0] x);
      logic signed [ACC_WIDTH-1:0] hi;
      logic signed [ACC_WIDTH-1:0] lo;
      hi = $signed({{(ACC_WIDTH-COEF_WIDTH+1){1'b0}}, {(COEF_WIDTH-1){1'b1}}});
      lo = ~hi;
      if (x > hi) begin
         return hi[COEF_WIDTH-1:0];
      end else if (x < lo) begin
         return lo[COEF_WIDTH-1:0];
      end
      return x[COEF_WIDTH-1:0];
   endfunction

   // x/2 rounded half away from zero
   function automatic logic signed [ACC_WIDTH-1:0] half_round(
         input logic signed [ACC_WIDTH-1:0] x);
      logic [ACC_WIDTH-1:0] m;
      logic [ACC_WIDTH-1:0] q;
      m = x[ACC_WIDTH-1] ? ACC_WIDTH'(-x) : ACC_WIDTH'(x);
      q = (m + ACC_WIDTH'(1)) >> 1;
      return x[ACC_WIDTH-1] ? $signed(-q) : $signed(q);
   endfunction

endpackage

/* sv/qss_div.sv */
`timescale 1ns / 1ps
module qss_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [qss_pkg::DVD_WIDTH-1:0]    dividend,
   input  logic [qss_pkg::DUR_WIDTH-1:0]    divisor,
   output logic [qss_pkg::DVD_WIDTH-1:0]    quotient,
   output logic [qss_pkg::DUR_WIDTH-1:0]    remainder,
   output logic                             done
);
   import qss_pkg::*;

   localparam int DCW = $clog2(DVD_WIDTH + 1);

   logic [DVD_WIDTH-1:0] quo_ff, quo_in;
   logic [DUR_WIDTH-1:0] rem_ff, rem_in;
   logic [DUR_WIDTH-1:0] dsr_ff, dsr_in;
   logic [DCW-1:0]       cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DUR_WIDTH:0]   trial;
   logic                 ge;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[DVD_WIDTH-1]};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = DCW'(DVD_WIDTH);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_WIDTH-2:0], ge};
         rem_in = ge ? DUR_WIDTH'(trial - {1'b0, dsr_ff}) : trial[DUR_WIDTH-1:0];
         cnt_in = cnt_ff - DCW'(1);
         if (cnt_ff == DCW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

/* sv/qss_dp.sv */
`timescale 1ns / 1ps
module qss_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  qss_pkg::req_type               req_data,
   input  logic [qss_pkg::CSR_WIDTH-1:0]  csr_data,
   input  logic                           csr_write,
   output qss_pkg::rsp_type               rsp_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  qss_pkg::cmd_type               cmd,
   output qss_pkg::status_type            status
);
   import qss_pkg::*;

   req_type                      in_ff;
   logic [CSR_WIDTH-1:0]         csr_ff;
   logic signed [COEF_WIDTH-1:0] coef_ff [NUM_COEFS];
   logic signed [COEF_WIDTH-1:0] v0t_ff, v1t_ff, b0_ff, b1_ff, tmp_ff;
   logic [MPROD_WIDTH-1:0]       prod_ff;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic                         neg_ff;
   logic signed [DATA_WIDTH-1:0] pos_ff, vel_ff;
   rsp_type                      rsp_ff;
   logic                         rsp_valid_ff;

   logic [IDX_WIDTH-1:0]         m_idx;

   // boundary-product multiplier, 24 x 31 bits per cycle
   logic signed [COEF_WIDTH-1:0]        src;
   logic                                src_neg;
   logic [COEF_WIDTH-1:0]               src_mag;
   logic [HALF_WIDTH-1:0]               mul_half;
   logic [HALF_WIDTH+DUR_WIDTH-1:0]     pp;
   logic [MPROD_WIDTH:0]                rnd;
   logic [MPROD_WIDTH-FRACTION_BITS:0]  shifted;
   logic [MPROD_WIDTH-FRACTION_BITS:0]  mlim;
   logic [COEF_WIDTH-1:0]               mmag;
   logic signed [COEF_WIDTH-1:0]        mul_res;

   // coefficient solve
   logic signed [ACC_WIDTH-1:0] h, ev0, ev1, eb0, eb1;
   logic signed [ACC_WIDTH-1:0] comb;
   logic signed [COEF_WIDTH-1:0] coef_new;

   // Horner and divider glue
   logic signed [PROD_WIDTH-1:0] prod_j;
   logic [PROD_WIDTH-1:0]        pj_mag;
   logic [ACC_WIDTH-1:0]         acc_mag;
   logic [DVD_WIDTH-1:0]         div_dvd;
   logic [DUR_WIDTH-1:0]         div_dsr;
   logic                         div_start;
   logic [DVD_WIDTH-1:0]         div_q;
   logic [DUR_WIDTH-1:0]         div_r;
   logic                         div_done;
   logic signed [ACC_WIDTH-1:0]  q_signed;
   logic signed [ACC_WIDTH-1:0]  wc;
   logic                         q_over;
   logic                         q_up;
   logic [COEF_WIDTH-1:0]        q_res;
   logic [COEF_WIDTH-1:0]        q_lim;
   logic [COEF_WIDTH-1:0]        q_mag;
   logic signed [COEF_WIDTH-1:0] divq_res;

   assign m_idx = last_index(csr_ff);

   always_comb begin
      case (cmd.mul_sel)
         MSTEP_V0:  src = COEF_WIDTH'(in_ff.start_velocity);
         MSTEP_V1:  src = COEF_WIDTH'(in_ff.end_velocity);
         MSTEP_A0T: src = COEF_WIDTH'(in_ff.start_acceleration);
         MSTEP_A1T: src = COEF_WIDTH'(in_ff.end_acceleration);
         default:   src = tmp_ff;
      endcase
   end

   assign src_neg  = src[COEF_WIDTH-1];
   assign src_mag  = src_neg ? COEF_WIDTH'(-src) : COEF_WIDTH'(src);
   assign mul_half = (cmd.op == OP_MUL_HI) ? src_mag[COEF_WIDTH-1:HALF_WIDTH]
                                           : src_mag[HALF_WIDTH-1:0];
   assign pp = (HALF_WIDTH+DUR_WIDTH)'(mul_half)
             * (HALF_WIDTH+DUR_WIDTH)'(in_ff.duration);

   always_comb begin
      rnd     = {1'b0, prod_ff} + (MPROD_WIDTH+1)'(1 << (FRACTION_BITS-1));
      shifted = rnd[MPROD_WIDTH:FRACTION_BITS];
      mlim    = (MPROD_WIDTH-FRACTION_BITS+1)'({1'b0, {(COEF_WIDTH-1){1'b1}}})
              + (MPROD_WIDTH-FRACTION_BITS+1)'(src_neg);
      mmag    = (shifted > mlim) ? mlim[COEF_WIDTH-1:0] : shifted[COEF_WIDTH-1:0];
      mul_res = src_neg ? $signed(-mmag) : $signed(mmag);
   end

   always_comb begin
      h   = ACC_WIDTH'(in_ff.end_position) - ACC_WIDTH'(in_ff.start_position);
      ev0 = ACC_WIDTH'(v0t_ff);
      ev1 = ACC_WIDTH'(v1t_ff);
      eb0 = ACC_WIDTH'(b0_ff);
      eb1 = ACC_WIDTH'(b1_ff);
      case (cmd.coef_k)
         3'd2:    comb = eb0;
         3'd3:    comb = 20 * h - 12 * ev0 - 8 * ev1 - 3 * eb0 + eb1;
         3'd4:    comb = -30 * h + 16 * ev0 + 14 * ev1 + 3 * eb0 - 2 * eb1;
         default: comb = 12 * h - 6 * ev0 - 6 * ev1 - eb0 + eb1;
      endcase
      case (cmd.coef_k)
         3'd0:    coef_new = COEF_WIDTH'(in_ff.start_position);
         3'd1:    coef_new = v0t_ff;
         default: coef_new = sat_coef(half_round(comb));
      endcase
   end

   always_comb begin
      prod_j  = PROD_WIDTH'(acc_ff) * $signed({1'b0, cmd.j});
      pj_mag  = prod_j[PROD_WIDTH-1] ? PROD_WIDTH'(-prod_j) : PROD_WIDTH'(prod_j);
      acc_mag = acc_ff[ACC_WIDTH-1] ? ACC_WIDTH'(-acc_ff) : ACC_WIDTH'(acc_ff);
      div_start = 1'b0;
      div_dvd   = DVD_WIDTH'(acc_mag) << FRACTION_BITS;
      div_dsr   = in_ff.duration;
      case (cmd.op)
         OP_H_DIV: begin
            div_start = 1'b1;
            div_dvd   = DVD_WIDTH'(pj_mag) + DVD_WIDTH'(m_idx >> 1);
            div_dsr   = DUR_WIDTH'(m_idx);
         end
         OP_Q_START: div_start = 1'b1;
         default: div_start = 1'b0;
      endcase
   end

   qss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .quotient  (div_q),
      .remainder (div_r),
      .done      (div_done)
   );

   always_comb begin
      q_signed = neg_ff ? $signed(-ACC_WIDTH'(div_q)) : $signed(ACC_WIDTH'(div_q));
      wc = ACC_WIDTH'(coef_ff[cmd.coef_k])
         * $signed({1'b0, horner_weight(cmd.coef_k, cmd.form)});
      // fixed-point quotient by T, rounded and saturated to coefficient width
      q_over   = |div_q[DVD_WIDTH-1:COEF_WIDTH-1];
      q_up     = {div_r, 1'b0} >= {1'b0, in_ff.duration};
      q_res    = div_q[COEF_WIDTH-1:0] + COEF_WIDTH'(q_up);
      q_lim    = {1'b0, {(COEF_WIDTH-1){1'b1}}} + COEF_WIDTH'(neg_ff);
      q_mag    = (q_over || q_res > q_lim) ? q_lim : q_res;
      divq_res = neg_ff ? $signed(-q_mag) : $signed(q_mag);
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD:   in_ff <= req_data;
         OP_MUL_LO: prod_ff <= MPROD_WIDTH'(pp);
         OP_MUL_HI: prod_ff <= prod_ff + (MPROD_WIDTH'(pp) << HALF_WIDTH);
         OP_MUL_WR: begin
            case (cmd.mul_sel)
               MSTEP_V0: v0t_ff <= mul_res;
               MSTEP_V1: v1t_ff <= mul_res;
               MSTEP_B0: b0_ff  <= mul_res;
               MSTEP_B1: b1_ff  <= mul_res;
               default:  tmp_ff <= mul_res;
            endcase
         end
         OP_COEF:    coef_ff[cmd.coef_k] <= coef_new;
         OP_H_INIT:  acc_ff <= '0;
         OP_H_DIV:   neg_ff <= prod_j[PROD_WIDTH-1];
         OP_H_ADD:   acc_ff <= q_signed + wc;
         OP_Q_START: neg_ff <= acc_ff[ACC_WIDTH-1];
         OP_Q_WR:    acc_ff <= ACC_WIDTH'(divq_res);
         OP_SET_POS: pos_ff <= sat_data(acc_ff);
         OP_SET_VEL: vel_ff <= sat_data(acc_ff);
         OP_EMIT: begin
            rsp_ff.axis_out            <= in_ff.axis_tag;
            rsp_ff.sample_index        <= cmd.j;
            rsp_ff.sample_position     <= pos_ff;
            rsp_ff.sample_velocity     <= vel_ff;
            rsp_ff.sample_acceleration <= sat_data(acc_ff);
            rsp_ff.last_sample         <= cmd.last;
            rsp_ff.singular_error      <= 1'b0;
         end
         OP_EMIT_ERR: begin
            rsp_ff.axis_out            <= req_data.axis_tag;
            rsp_ff.sample_index        <= '0;
            rsp_ff.sample_position     <= '0;
            rsp_ff.sample_velocity     <= '0;
            rsp_ff.sample_acceleration <= '0;
            rsp_ff.last_sample         <= 1'b1;
            rsp_ff.singular_error      <= 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CSR_WIDTH'(CSR_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            csr_ff <= csr_data;
         end
         if (cmd.op == OP_EMIT || cmd.op == OP_EMIT_ERR) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_data          = rsp_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign status.dur_zero   = (req_data.duration == '0);
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.last_index = m_idx;

endmodule

/* sv/qss_ctrl.sv */
`timescale 1ns / 1ps
module qss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qss_pkg::status_type  status,
   output qss_pkg::cmd_type     cmd
);
   import qss_pkg::*;

   state_type             state_ff, state_in;
   logic [MSEL_WIDTH-1:0] mul_sel_ff, mul_sel_in;
   logic [KIDX_WIDTH-1:0] k_ff, k_in;
   logic [1:0]            f_ff, f_in;
   logic [CNT_WIDTH-1:0]  j_ff, j_in;
   logic                  qpass_ff, qpass_in;
   logic                  is_last;

   assign is_last = (j_ff == CNT_WIDTH'(status.last_index));

   always_comb begin
      state_in   = state_ff;
      mul_sel_in = mul_sel_ff;
      k_in       = k_ff;
      f_in       = f_ff;
      j_in       = j_ff;
      qpass_in   = qpass_ff;
      cmd.op      = OP_NONE;
      cmd.mul_sel = mul_sel_ff;
      cmd.coef_k  = k_ff;
      cmd.form    = f_ff;
      cmd.j       = j_ff[IDX_WIDTH-1:0];
      cmd.last    = is_last;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.dur_zero) begin
                  state_in = ST_ERR;
               end else begin
                  cmd.op     = OP_LOAD;
                  mul_sel_in = MSTEP_V0;
                  state_in   = ST_MUL_LO;
               end
            end
         end
         ST_ERR: begin
            // payload is still held on the input port
            if (status.out_free) begin
               cmd.op   = OP_EMIT_ERR;
               state_in = ST_IDLE;
            end
         end
         ST_MUL_LO: begin
            cmd.op   = OP_MUL_LO;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.op   = OP_MUL_HI;
            state_in = ST_MUL_WR;
         end
         ST_MUL_WR: begin
            cmd.op = OP_MUL_WR;
            if (mul_sel_ff == MSTEP_B1) begin
               k_in     = '0;
               state_in = ST_COEF;
            end else begin
               mul_sel_in = mul_sel_ff + MSEL_WIDTH'(1);
               state_in   = ST_MUL_LO;
            end
         end
         ST_COEF: begin
            cmd.op = OP_COEF;
            if (k_ff == KIDX_WIDTH'(NUM_COEFS - 1)) begin
               j_in     = '0;
               f_in     = FORM_POS;
               state_in = ST_H_INIT;
            end else begin
               k_in = k_ff + KIDX_WIDTH'(1);
            end
         end
         ST_H_INIT: begin
            cmd.op   = OP_H_INIT;
            k_in     = KIDX_WIDTH'(NUM_COEFS - 1);
            qpass_in = 1'b0;
            state_in = ST_H_DIV;
         end
         ST_H_DIV: begin
            cmd.op   = OP_H_DIV;
            state_in = ST_H_WAIT;
         end
         ST_H_WAIT: begin
            if (status.div_done) begin
               state_in = ST_H_ADD;
            end
         end
         ST_H_ADD: begin
            cmd.op = OP_H_ADD;
            if (k_ff == {1'b0, f_ff}) begin
               state_in = (f_ff == FORM_POS) ? ST_SAVE : ST_Q_START;
            end else begin
               k_in     = k_ff - KIDX_WIDTH'(1);
               state_in = ST_H_DIV;
            end
         end
         ST_Q_START: begin
            cmd.op   = OP_Q_START;
            state_in = ST_Q_WAIT;
         end
         ST_Q_WAIT: begin
            if (status.div_done) begin
               state_in = ST_Q_WR;
            end
         end
         ST_Q_WR: begin
            cmd.op = OP_Q_WR;
            if (f_ff == FORM_VEL) begin
               state_in = ST_SAVE;
            end else if (!qpass_ff) begin
               // acceleration divides by T twice
               qpass_in = 1'b1;
               state_in = ST_Q_START;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SAVE: begin
            cmd.op   = (f_ff == FORM_POS) ? OP_SET_POS : OP_SET_VEL;
            f_in     = f_ff + 2'd1;
            state_in = ST_H_INIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT;
               if (is_last) begin
                  j_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  j_in     = j_ff + CNT_WIDTH'(1);
                  f_in     = FORM_POS;
                  state_in = ST_H_INIT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mul_sel_ff <= '0;
         k_ff       <= '0;
         f_ff       <= FORM_POS;
         j_ff       <= '0;
         qpass_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mul_sel_ff <= mul_sel_in;
         k_ff       <= k_in;
         f_ff       <= f_in;
         j_ff       <= j_in;
         qpass_ff   <= qpass_in;
      end
   end

   // in the zero-duration case the item is held until the error result is loaded
   assign req_stall = (state_ff == ST_ERR) ? !status.out_free
                    : ((state_ff != ST_IDLE) || status.dur_zero);

`ifndef NO_ASSERTIONS
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && status.out_free && is_last) |=> (state_ff == ST_IDLE))
      else $error("last sample did not return to idle");

   a_add_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_H_ADD) |-> $past(status.div_done))
      else $error("Horner add without finished division");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (j_ff <= CNT_WIDTH'(status.last_index)))
      else $error("sample index beyond sample count");

   a_idle_counter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (j_ff == '0))
      else $error("sample counter not cleared in idle");
`endif

endmodule

/* sv/quintic_segment_sampler.sv */
`timescale 1ns / 1ps
// Quintic segment sampler: each item is one axis of one segment (boundary
// position, velocity, acceleration in Q16.16 and duration T). The block solves
// the fifth-order polynomial and emits sample_count samples (2..64, both ends
// included) of position, velocity and acceleration, last one flagged. A zero
// duration gives one result with singular_error set. One item at a time: the
// coefficient solve comes first, then every sample runs 15 Horner divisions
// by (sample_count-1) and 3 divisions by T on one shared bit-serial 72-bit
// divider, and each result can be held up by a stall on the result side.
module quintic_segment_sampler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  qss_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output qss_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [qss_pkg::CSR_WIDTH-1:0]  csr_data
);
   import qss_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   qss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   qss_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .csr_write (csr_valid && csr_ready),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* bench/quintic_segment_sampler_tb.sv */
`timescale 1ns / 1ps
module quintic_segment_sampler_tb;
   import qss_pkg::*;

   localparam longint COEF_MAX = (64'sd1 <<< 47) - 1;
   localparam longint COEF_MIN = -(64'sd1 <<< 47);
   localparam int     CYCLE_LIMIT = 200_000_000;
   localparam int     DRAIN_CYCLES = 3000;

   typedef struct {
      int      cfg;       // register value written before the item, -1 for none
      req_type item;
      bit      typed;     // expected result written out below
   } row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_WIDTH-1:0] csr_data;

   rsp_type   pending_samples[$];
   longint    segment_coefs[6];
   int        sample_count_reg;
   int        cycle_count;
   int        mismatch_count;
   bit        quiet_phase;
   row_type   directed[$];

   quintic_segment_sampler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      cycle_count = 0;
      forever begin
         #10 clock = 1'b1;
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         #10 clock = 1'b0;
      end
   end

   // ---------------- fixed-point arithmetic of the segment solve ----------------

   function automatic longint sat_bits(longint x, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   function automatic longint apply_sign(bit neg, longint unsigned m);
      longint unsigned lim;
      lim = neg ? 64'd1 << 47 : (64'd1 << 47) - 1;
      if (m > lim) m = lim;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned magnitude(longint x);
      return (x < 0) ? longint'(0) - x : x;
   endfunction

   // x/d rounded half away from zero, d > 0
   function automatic longint div_round(longint x, longint d);
      longint unsigned q;
      q = (magnitude(x) + longint'(d / 2)) / d;
      return (x < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint q16_mul(longint a, longint b);
      logic [127:0] p;
      bit           neg;
      neg = (a < 0) != (b < 0);
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      p = (p + 128'd32768) >> FRACTION_BITS;
      if (p > 128'(64'd1 << 47)) p = 128'(64'd1 << 47);
      return apply_sign(neg, p[63:0]);
   endfunction

   function automatic longint q16_div(longint x, longint unsigned t);
      longint unsigned ux, q, r, res, rem;
      ux = magnitude(x);
      q = ux / t;
      r = ux % t;
      if (q >= (64'd1 << 31)) return (x < 0) ? COEF_MIN : COEF_MAX;
      res = (q << FRACTION_BITS) + ((r << FRACTION_BITS) / t);
      rem = (r << FRACTION_BITS) % t;
      if (2 * rem >= t) res++;
      return apply_sign(x < 0, res);
   endfunction

   // weighted polynomial in s = j/m; from = derivative order
   function automatic longint eval_poly(int from, longint j, longint m);
      longint acc;
      longint w;
      acc = 0;
      for (int k = 5; k >= from; k--) begin
         w = 1;
         for (int i = 0; i < from; i++) w *= (k - i);
         acc = div_round(acc * j, m) + w * segment_coefs[k];
      end
      return acc;
   endfunction

   task automatic predict_segment(req_type r);
      longint        p0, h, v0t, v1t, b0, b1, m, n;
      longint unsigned t;
      rsp_type       s;
      n = sample_count_reg;
      if (n < 2) n = 2;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      m = n - 1;
      t = r.duration;
      if (t == 0) begin
         s = '{axis_out: r.axis_tag, sample_index: '0, sample_position: '0,
               sample_velocity: '0, sample_acceleration: '0, last_sample: 1'b1,
               singular_error: 1'b1};
         pending_samples.push_back(s);
         return;
      end
      p0  = r.start_position;
      h   = longint'(r.end_position) - p0;
      v0t = q16_mul(r.start_velocity, t);
      v1t = q16_mul(r.end_velocity, t);
      b0  = q16_mul(q16_mul(r.start_acceleration, t), t);
      b1  = q16_mul(q16_mul(r.end_acceleration, t), t);
      segment_coefs[0] = p0;
      segment_coefs[1] = v0t;
      segment_coefs[2] = sat_bits(div_round(b0, 2), 48);
      segment_coefs[3] = sat_bits(div_round(20*h - 12*v0t - 8*v1t - 3*b0 + b1, 2), 48);
      segment_coefs[4] = sat_bits(div_round(-30*h + 16*v0t + 14*v1t + 3*b0 - 2*b1, 2), 48);
      segment_coefs[5] = sat_bits(div_round(12*h - 6*v0t - 6*v1t - b0 + b1, 2), 48);
      for (longint j = 0; j < n; j++) begin
         s.axis_out            = r.axis_tag;
         s.sample_index        = j[IDX_WIDTH-1:0];
         s.sample_position     = 32'(sat_bits(eval_poly(0, j, m), 32));
         s.sample_velocity     = 32'(sat_bits(q16_div(eval_poly(1, j, m), t), 32));
         s.sample_acceleration = 32'(sat_bits(q16_div(q16_div(eval_poly(2, j, m), t), t), 32));
         s.last_sample         = (j == n - 1);
         s.singular_error      = 1'b0;
         pending_samples.push_back(s);
      end
   endtask

   // ---------------- result side ----------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected sample: axis %0d idx %0d", rsp_data.axis_out,
                        rsp_data.sample_index);
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data.axis_out !== want.axis_out
                  || rsp_data.sample_index !== want.sample_index
                  || rsp_data.sample_position !== want.sample_position
                  || rsp_data.sample_velocity !== want.sample_velocity
                  || rsp_data.sample_acceleration !== want.sample_acceleration
                  || rsp_data.last_sample !== want.last_sample
                  || rsp_data.singular_error !== want.singular_error) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %0d %0d %h %h %h %b %b got %0d %0d %h %h %h %b %b",
                           want.axis_out, want.sample_index, want.sample_position,
                           want.sample_velocity, want.sample_acceleration,
                           want.last_sample, want.singular_error,
                           rsp_data.axis_out, rsp_data.sample_index,
                           rsp_data.sample_position, rsp_data.sample_velocity,
                           rsp_data.sample_acceleration, rsp_data.last_sample,
                           rsp_data.singular_error);
            end
         end
      end
   end

   // output back-pressure in bursts
   int stall_left;
   int open_left;
   always @(posedge clock) begin
      if (reset || quiet_phase) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         open_left  <= $urandom_range(1, 40);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (open_left > 0) begin
         open_left <= open_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         stall_left <= $urandom_range(1, 18);
         open_left  <= $urandom_range(1, 60);
         rsp_stall  <= 1'b1;
      end
   end

   // ---------------- input side ----------------

   task automatic send_segment(req_type r, bit typed);
      rsp_type s;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         s = '{axis_out: r.axis_tag, sample_index: '0, sample_position: '0,
               sample_velocity: '0, sample_acceleration: '0, last_sample: 1'b1,
               singular_error: 1'b1};
         pending_samples.push_back(s);
      end else begin
         predict_segment(r);
      end
   endtask

   task automatic drain_samples();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_sample_count(int value);
      drain_samples();
      csr_valid <= 1'b1;
      csr_data  <= CSR_WIDTH'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sample_count_reg = value;
   endtask

   task automatic sender_gap();
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   function automatic row_type make_row(int cfg, logic [1:0] ax, int p0, int p1, int v0,
                                        int v1, int a0, int a1, logic [30:0] dur, bit typed);
      row_type rw;
      rw.cfg  = cfg;
      rw.item = '{axis_tag: ax, start_position: p0, end_position: p1, start_velocity: v0,
                  end_velocity: v1, start_acceleration: a0, end_acceleration: a1,
                  duration: dur};
      rw.typed = typed;
      return rw;
   endfunction

   function automatic req_type random_segment();
      req_type r;
      int      mode;
      int      sh;
      mode = $urandom_range(0, 9);
      r.axis_tag = 2'($urandom_range(0, 3));
      if (mode <= 1) begin
         // full-range noise; saturation everywhere
         r.start_position     = $urandom;
         r.end_position       = $urandom;
         r.start_velocity     = $urandom;
         r.end_velocity       = $urandom;
         r.start_acceleration = $urandom;
         r.end_acceleration   = $urandom;
         r.duration           = (mode == 0) ? 31'd0 : 31'($urandom);
      end else begin
         sh = $urandom_range(4, 14);
         r.start_position     = $signed($urandom) >>> sh;
         r.end_position       = $signed($urandom) >>> sh;
         r.start_velocity     = $signed($urandom) >>> (sh + 2);
         r.end_velocity       = $signed($urandom) >>> (sh + 2);
         r.start_acceleration = $signed($urandom) >>> (sh + 4);
         r.end_acceleration   = $signed($urandom) >>> (sh + 4);
         r.duration           = 31'($urandom_range(32'h1000, 32'h80000));
      end
      return r;
   endfunction

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      quiet_phase      = 1'b0;
      mismatch_count   = 0;
      sample_count_reg = CSR_RESET;
      foreach (segment_coefs[k]) segment_coefs[k] = 0;

      directed.push_back(make_row(-1,  0, 0, 0, 0, 0, 0, 0, 31'h10000, 0));
      directed.push_back(make_row( 2,  1, 0, 32'h10000, 0, 0, 0, 0, 31'd0, 1));
      directed.push_back(make_row(-1,  2, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 0));
      directed.push_back(make_row(-1,  0, 32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h80000000, 32'h80000000, 31'd1, 0));
      directed.push_back(make_row(-1,  1, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0,
                                  31'h10000, 0));
      directed.push_back(make_row(-1,  3, 32'h00030000, -32'sh00050000, 32'h8000,
                                  -32'sh8000, 32'h100, -32'sh100, 31'h20000, 0));
      directed.push_back(make_row(-1,  3, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                  32'h80000000, 32'h7fffffff, 32'h80000000, 31'd0, 1));
      directed.push_back(make_row( 0,  2, 32'h00010000, 32'h00020000, 0, 0, 0, 0,
                                  31'h10000, 0));
      directed.push_back(make_row( 1,  0, 32'h00010000, 32'hffff0000, 32'h10000, 0, 0, 0,
                                  31'h18000, 0));
      directed.push_back(make_row(127, 1, 0, 32'h00640000, 0, 0, 0, 0, 31'h30000, 0));
      directed.push_back(make_row(65,  2, 32'hfff00000, 32'h00100000, 32'h20000,
                                  32'h20000, 0, 0, 31'h40000, 0));
      directed.push_back(make_row(64,  0, 32'h12345678, -32'sh1234567, 32'h1000,
                                  -32'sh2000, 32'h400, 32'h800, 31'h20000, 0));
      directed.push_back(make_row( 3,  1, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000,
                                  31'h7fffffff, 0));
      directed.push_back(make_row(-1,  2, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                                  32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 31'h55555555, 0));
      directed.push_back(make_row(-1,  3, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                                  32'h55555555, 32'haaaaaaaa, 32'h55555555, 31'h2aaaaaaa, 0));
      directed.push_back(make_row(-1,  0, 32'h00008000, 32'h00008001, 1, -1, 1, -1,
                                  31'h8000, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].cfg >= 0) write_sample_count(directed[i].cfg);
         send_segment(directed[i].item, directed[i].typed);
         sender_gap();
      end

      for (int phase = 0; phase < 14; phase++) begin
         case (phase)
            3:       write_sample_count(0);
            7:       write_sample_count(1);
            10:      write_sample_count(8);
            default: write_sample_count($urandom_range(2, 5));
         endcase
         if (phase == 12) quiet_phase = 1'b1;
         for (int n = 0; n < 30; n++) begin
            if (phase == 5 && n == 15) drain_samples();
            send_segment(random_segment(), 1'b0);
            sender_gap();
         end
      end
      req_valid <= 1'b0;

      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
